### rtl/rad_pkg.sv
// ============================================================================
// rad_pkg
// Shared types and constants for the RTP audio depacketizer.
// ============================================================================
package rad_pkg;

    // Field widths fixed by the interface.
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 13;
    localparam int SEQ_W  = 16;
    localparam int PT_W   = 7;
    localparam int CSRC_W = 4;
    localparam int BASE_W = 7;   // 12 + 4 * 15 = 72 fits in seven bits
    localparam int HDR_W  = 19;  // 76 + 4 * 65535 = 262216 fits in 19 bits

    // RTP header constants.
    localparam logic [BASE_W-1:0] MIN_HEADER_BYTES = 7'd12;
    localparam logic [PT_W-1:0]   PT_RESET_VALUE   = 7'd111;
    localparam int                EXT_BIT          = 4;

    // Decoupling queue between the parser and the frame builder.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One payload byte as handed from the parser to the frame builder.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;   // final payload byte of the frame
        logic              first;  // first payload byte: prefix goes out ahead
        logic [SEQ_W-1:0]  seq;    // sequence number for the prefix
    } rad_entry_t;

endpackage

### rtl/rad_front.sv
// ============================================================================
// rad_front
// Header parser: tracks the byte position, decodes the RTP header fields and
// decides for each accepted byte whether it is a payload byte to forward.
// ============================================================================
module rad_front
    import rad_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = 4096
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [PT_W-1:0]   cfg_wdata,
    input  logic              accept,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic [LEN_W-1:0]  packet_length,
    input  logic              last_byte,
    output logic              push,
    output rad_entry_t        push_entry
);

    localparam int POS_W = $clog2(MAX_PACKET_BYTES + 1);
    localparam int CMP_W = (POS_W > HDR_W) ? POS_W : HDR_W;
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_PACKET_BYTES);

    logic [PT_W-1:0]   pt_reg;
    logic [POS_W-1:0]  pos_reg,     pos_next;
    logic [SEQ_W-1:0]  seq_reg,     seq_next;
    logic [CSRC_W-1:0] csrc_reg,    csrc_next;
    logic              ext_reg,     ext_next;
    logic [BYTE_W-1:0] ext_hi_reg,  ext_hi_next;
    logic [HDR_W-1:0]  hdr_len_reg, hdr_len_next;
    logic              discard_reg, discard_next;

    logic [BASE_W-1:0] base_new;
    logic [BASE_W-1:0] base_cur;
    logic [CMP_W-1:0]  pos_x;
    logic [CMP_W-1:0]  len_x;
    logic [CMP_W-1:0]  hdr_x;
    logic [CMP_W-1:0]  ext_total;
    logic              ext_fits;
    logic              emit;
    logic              fin;

    assign pos_x     = CMP_W'(pos_reg);
    assign len_x     = CMP_W'(packet_length);
    assign hdr_x     = CMP_W'(hdr_len_reg);
    assign base_new  = MIN_HEADER_BYTES + {1'b0, data_byte[CSRC_W-1:0], 2'b00};
    assign base_cur  = MIN_HEADER_BYTES + {1'b0, csrc_reg, 2'b00};
    assign ext_fits  = (CMP_W'(base_new) + CMP_W'(4)) <= len_x;
    assign ext_total = CMP_W'(base_cur) + CMP_W'(4) + CMP_W'({ext_hi_reg, data_byte, 2'b00});

    // Position zero is excluded because the header length is still cleared there.
    assign emit = (pos_reg != '0) && !discard_reg && !ext_reg
                  && (pos_x >= hdr_x) && (pos_x < len_x);
    assign fin  = last_byte || ((pos_x + CMP_W'(1)) == len_x);

    assign push             = accept && emit;
    assign push_entry.data  = data_byte;
    assign push_entry.last  = fin;
    assign push_entry.first = (pos_x == hdr_x);
    assign push_entry.seq   = seq_reg;

    always_comb
    begin
        pos_next     = pos_reg;
        seq_next     = seq_reg;
        csrc_next    = csrc_reg;
        ext_next     = ext_reg;
        ext_hi_next  = ext_hi_reg;
        hdr_len_next = hdr_len_reg;
        discard_next = discard_reg;
        if (accept)
        begin
            case (pos_reg)
                POS_W'(0):
                begin
                    csrc_next    = data_byte[CSRC_W-1:0];
                    hdr_len_next = HDR_W'(base_new);
                    ext_next     = data_byte[EXT_BIT] && ext_fits;
                    discard_next = (len_x < CMP_W'(MIN_HEADER_BYTES))
                                   || (32'(packet_length) > MAX_PACKET_BYTES)
                                   || (!(data_byte[EXT_BIT] && ext_fits)
                                       && (CMP_W'(base_new) >= len_x));
                end
                POS_W'(1):
                begin
                    if (data_byte[PT_W-1:0] != pt_reg)
                    begin
                        discard_next = 1'b1;
                    end
                end
                POS_W'(2):
                begin
                    seq_next[15:8] = data_byte;
                end
                POS_W'(3):
                begin
                    seq_next[7:0] = data_byte;
                end
                default:
                begin
                end
            endcase

            if (ext_reg && (pos_x >= CMP_W'(4)))
            begin
                if (pos_x == (CMP_W'(base_cur) + CMP_W'(2)))
                begin
                    ext_hi_next = data_byte;
                end
                else if (pos_x == (CMP_W'(base_cur) + CMP_W'(3)))
                begin
                    hdr_len_next = HDR_W'(ext_total);
                    ext_next     = 1'b0;
                    if (ext_total >= len_x)
                    begin
                        discard_next = 1'b1;
                    end
                end
            end

            if (emit && fin)
            begin
                discard_next = 1'b1;
            end

            if (last_byte)
            begin
                pos_next     = '0;
                seq_next     = '0;
                csrc_next    = '0;
                ext_next     = 1'b0;
                ext_hi_next  = '0;
                hdr_len_next = '0;
                discard_next = 1'b0;
            end
            else if (pos_reg < POS_MAX)
            begin
                pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pt_reg      <= PT_RESET_VALUE;
            pos_reg     <= '0;
            seq_reg     <= '0;
            csrc_reg    <= '0;
            ext_reg     <= 1'b0;
            ext_hi_reg  <= '0;
            hdr_len_reg <= '0;
            discard_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                pt_reg <= cfg_wdata;
            end
            pos_reg     <= pos_next;
            seq_reg     <= seq_next;
            csrc_reg    <= csrc_next;
            ext_reg     <= ext_next;
            ext_hi_reg  <= ext_hi_next;
            hdr_len_reg <= hdr_len_next;
            discard_reg <= discard_next;
        end
    end

endmodule

### rtl/rad_queue.sv
// ============================================================================
// rad_queue
// Small register queue that decouples the parser from the frame builder.
// ============================================================================
module rad_queue
    import rad_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  rad_entry_t        push_entry,
    input  logic              pop,
    output rad_entry_t        head_entry,
    output logic [QCNT_W-1:0] count
);

    rad_entry_t          slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;

    assign head_entry = slot_reg[rd_ptr_reg];
    assign count      = count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_reg + QCNT_W'(push) - QCNT_W'(pop);
        end
    end

endmodule

### rtl/rad_back.sv
// ============================================================================
// rad_back
// Frame builder: emits the four-byte prefix ahead of the first payload byte
// and one output beat per payload byte.
// ============================================================================
module rad_back
    import rad_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  rad_entry_t        q_entry,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [BYTE_W-1:0] out_byte,
    output logic              out_last
);

    typedef enum logic [2:0] {
        PH_SEQ_LO,
        PH_SEQ_HI,
        PH_PAD0,
        PH_PAD1,
        PH_DATA
    } phase_t;

    phase_t     phase_reg;
    logic       busy_reg;
    rad_entry_t cur_reg;
    logic       final_beat;

    assign final_beat = busy_reg && out_ready && (phase_reg == PH_DATA);
    assign q_pop      = q_valid && (!busy_reg || final_beat);
    assign out_valid  = busy_reg;
    assign out_last   = (phase_reg == PH_DATA) && cur_reg.last;

    always_comb
    begin
        case (phase_reg)
            PH_SEQ_LO: out_byte = cur_reg.seq[7:0];
            PH_SEQ_HI: out_byte = cur_reg.seq[15:8];
            PH_DATA:   out_byte = cur_reg.data;
            default:   out_byte = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            phase_reg <= PH_DATA;
        end
        else if (q_pop)
        begin
            busy_reg  <= 1'b1;
            phase_reg <= q_entry.first ? PH_SEQ_LO : PH_DATA;
        end
        else if (busy_reg && out_ready)
        begin
            case (phase_reg)
                PH_SEQ_LO: phase_reg <= PH_SEQ_HI;
                PH_SEQ_HI: phase_reg <= PH_PAD0;
                PH_PAD0:   phase_reg <= PH_PAD1;
                PH_PAD1:   phase_reg <= PH_DATA;
                default:   busy_reg  <= 1'b0;
            endcase
        end
    end

endmodule

### rtl/rtp_audio_depacketizer_unit.sv
// ============================================================================
// rtp_audio_depacketizer_unit
// Strips RTP headers and rebuilds audio frames with a sequence-number prefix.
// ============================================================================
// The block takes one RTP packet byte per beat and can accept a byte in every
// clock cycle while in_ready is high. A header parser checks the length,
// payload type, CSRC count and header extension; a packet that is too short,
// too long, of the wrong type or whose header does not end before the packet
// does gives no output. For a kept packet the frame starts with the sequence
// number low byte, high byte, two zero bytes, and then the payload bytes, with
// out_last on the last one. The parser and the frame builder are joined by a
// four-entry queue. The first payload byte of a frame turns into five output
// beats; with back-to-back input and a free output the queue takes up part of
// that burst and in_ready may drop, after which bytes stream at one per cycle
// again, and the header bytes of the next packet give no output and let the
// queue drain. The output side delivers at most one beat per cycle, which
// sets the sustained throughput at one byte per cycle. in_ready drops only
// while that queue is full. An accepted payload byte passes through the queue
// and then the builder's entry register before its first output beat. The
// payload type register is written through cfg_we/cfg_wdata and resets to 111.
module rtp_audio_depacketizer_unit
    import rad_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = 4096
) (
    input  logic              clk,
    input  logic              rst_n,
    // Configuration
    input  logic              cfg_we,
    input  logic [PT_W-1:0]   cfg_wdata,
    // Packet bytes in
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic [LEN_W-1:0]  packet_length,
    input  logic              last_byte,
    // Frame bytes out
    output logic              out_valid,
    input  logic              out_ready,
    output logic [BYTE_W-1:0] out_byte,
    output logic              out_last
);

    logic              in_fire;
    logic              q_push;
    logic              q_pop;
    rad_entry_t        q_in;
    rad_entry_t        q_head;
    logic [QCNT_W-1:0] q_count;

    // The queue count is a register, so ready never depends on the input valid.
    assign in_ready = (q_count != QCNT_W'(QUEUE_DEPTH));
    assign in_fire  = in_valid && in_ready;

    rad_front #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .accept        (in_fire),
        .data_byte     (data_byte),
        .packet_length (packet_length),
        .last_byte     (last_byte),
        .push          (q_push),
        .push_entry    (q_in)
    );

    rad_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_in),
        .pop        (q_pop),
        .head_entry (q_head),
        .count      (q_count)
    );

    // The builder pops the next entry in the same cycle its current frame
    // byte leaves, so back-to-back payload bytes stream without a bubble.
    rad_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_count != '0),
        .q_entry   (q_head),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .out_last  (out_last)
    );

    // The queue occupancy never exceeds its depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue occupancy above depth");

    // An entry is only taken from a non-empty queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (q_count != '0))
        else $error("pop from empty queue");

    // Occupancy follows pushes and pops exactly.
    assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (q_count == ($past(q_count) + QCNT_W'($past(q_push))
                              - QCNT_W'($past(q_pop)))))
        else $error("queue count out of step with push and pop");

    // A payload byte is only forwarded from a beat that was accepted.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> in_fire)
        else $error("queue push without an accepted input beat");

endmodule
